// ----- sv/vtdb_pkg.sv -----
// Shared types and constants for the vertex transform, decimation and bounding box block.
package vtdb_pkg;

    localparam int unsigned RAW_W   = 8;
    localparam int unsigned BASE_W  = 16;
    localparam int unsigned COORD_W = 20;
    localparam int unsigned BOX_W   = 16;
    localparam int unsigned SHIFT_W = 4;
    localparam int unsigned TRIG_W  = 12;
    localparam int unsigned LEVEL_W = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    // raw byte shifted left by up to 15
    localparam int unsigned SCALED_W = RAW_W + (1 << SHIFT_W) - 1;
    localparam int unsigned PROD_W   = SCALED_W + 1 + TRIG_W;
    localparam int unsigned ROT_FRAC = 10;

    localparam logic [LEVEL_W-1:0] SCALE_COARSE = LEVEL_W'(5);
    localparam logic signed [COORD_W:0] LIMIT_FINE   = (COORD_W+1)'(3);
    localparam logic signed [COORD_W:0] LIMIT_COARSE = (COORD_W+1)'(4);

    localparam logic signed [TRIG_W-1:0] COS_RESET = TRIG_W'(1024);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_SHIFT    = 3'd0,
        REG_RIGHT_SHIFT   = 3'd1,
        REG_ROTATE_ENABLE = 3'd2,
        REG_COS_TERM      = 3'd3,
        REG_SIN_TERM      = 3'd4,
        REG_SCALE_LEVEL   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [SHIFT_W-1:0]        left_shift;
        logic [SHIFT_W-1:0]        right_shift;
        logic                      rotate_enable;
        logic signed [TRIG_W-1:0]  cos_term;
        logic signed [TRIG_W-1:0]  sin_term;
        logic [LEVEL_W-1:0]        scale_level;
    } cfg_t;

    typedef struct packed {
        logic signed [BOX_W-1:0] min_x;
        logic signed [BOX_W-1:0] max_x;
        logic signed [BOX_W-1:0] min_y;
        logic signed [BOX_W-1:0] max_y;
    } box_t;

endpackage

// ----- sv/vtdb_config.sv -----
// Configuration register bank for the vertex transform block.
module vtdb_config (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [vtdb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vtdb_pkg::CFG_DATA_W-1:0]     cfg_data,
    output vtdb_pkg::cfg_t                      cfg
);

    vtdb_pkg::cfg_t cfg_reg;
    vtdb_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (vtdb_pkg::cfg_index_t'(cfg_index))
                vtdb_pkg::REG_LEFT_SHIFT: begin
                    cfg_next.left_shift = cfg_data[vtdb_pkg::SHIFT_W-1:0];
                end
                vtdb_pkg::REG_RIGHT_SHIFT: begin
                    cfg_next.right_shift = cfg_data[vtdb_pkg::SHIFT_W-1:0];
                end
                vtdb_pkg::REG_ROTATE_ENABLE: begin
                    cfg_next.rotate_enable = cfg_data[0];
                end
                vtdb_pkg::REG_COS_TERM: begin
                    cfg_next.cos_term = $signed(cfg_data[vtdb_pkg::TRIG_W-1:0]);
                end
                vtdb_pkg::REG_SIN_TERM: begin
                    cfg_next.sin_term = $signed(cfg_data[vtdb_pkg::TRIG_W-1:0]);
                end
                vtdb_pkg::REG_SCALE_LEVEL: begin
                    cfg_next.scale_level = cfg_data[vtdb_pkg::LEVEL_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.left_shift    <= '0;
            cfg_reg.right_shift   <= '0;
            cfg_reg.rotate_enable <= 1'b0;
            cfg_reg.cos_term      <= vtdb_pkg::COS_RESET;
            cfg_reg.sin_term      <= '0;
            cfg_reg.scale_level   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/vtdb_transform.sv -----
// Scale, optional Q10 rotation and base offset of one vertex.
module vtdb_transform (
    input  vtdb_pkg::cfg_t                          cfg,
    input  logic [vtdb_pkg::RAW_W-1:0]              raw_x,
    input  logic [vtdb_pkg::RAW_W-1:0]              raw_y,
    input  logic signed [vtdb_pkg::BASE_W-1:0]      base_x,
    input  logic signed [vtdb_pkg::BASE_W-1:0]      base_y,
    output logic signed [vtdb_pkg::COORD_W-1:0]     point_x,
    output logic signed [vtdb_pkg::COORD_W-1:0]     point_y
);

    localparam int unsigned SW = vtdb_pkg::SCALED_W;
    localparam int unsigned CW = vtdb_pkg::COORD_W;
    localparam int unsigned PW = vtdb_pkg::PROD_W;
    localparam int unsigned FR = vtdb_pkg::ROT_FRAC;

    logic [SW-1:0]         tx;
    logic [SW-1:0]         ty;
    logic signed [SW:0]    tx_s;
    logic signed [SW:0]    ty_s;
    logic signed [PW-1:0]  p_xc;
    logic signed [PW-1:0]  p_ys;
    logic signed [PW-1:0]  p_xs;
    logic signed [PW-1:0]  p_yc;
    logic [CW-1:0]         bx;
    logic [CW-1:0]         by;

    always_comb begin
        tx   = ({{(SW - vtdb_pkg::RAW_W){1'b0}}, raw_x} << cfg.left_shift) >> cfg.right_shift;
        ty   = ({{(SW - vtdb_pkg::RAW_W){1'b0}}, raw_y} << cfg.left_shift) >> cfg.right_shift;
        tx_s = $signed({1'b0, tx});
        ty_s = $signed({1'b0, ty});
        p_xc = tx_s * cfg.cos_term;
        p_ys = ty_s * cfg.sin_term;
        p_xs = tx_s * cfg.sin_term;
        p_yc = ty_s * cfg.cos_term;
        bx   = {{(CW - vtdb_pkg::BASE_W){base_x[vtdb_pkg::BASE_W-1]}}, base_x};
        by   = {{(CW - vtdb_pkg::BASE_W){base_y[vtdb_pkg::BASE_W-1]}}, base_y};
        // arithmetic shift by the fraction width, wrapped to the coordinate width
        if (cfg.rotate_enable) begin
            point_x = $signed(bx + p_xc[FR+CW-1:FR] - p_ys[FR+CW-1:FR]);
            point_y = $signed(by - (p_xs[FR+CW-1:FR] + p_yc[FR+CW-1:FR]));
        end else begin
            point_x = $signed(bx + tx[CW-1:0]);
            point_y = $signed(by - ty[CW-1:0]);
        end
    end

endmodule

// ----- sv/vtdb_decimate.sv -----
// Decimation against the last kept vertex and running bounding box state.
module vtdb_decimate (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic [vtdb_pkg::LEVEL_W-1:0]            scale_level,
    input  logic                                    update,
    input  logic signed [vtdb_pkg::COORD_W-1:0]     point_x,
    input  logic signed [vtdb_pkg::COORD_W-1:0]     point_y,
    input  logic                                    first_vertex,
    input  logic                                    last_vertex,
    output logic                                    kept,
    output vtdb_pkg::box_t                          box
);

    localparam int unsigned CW = vtdb_pkg::COORD_W;
    localparam int unsigned BW = vtdb_pkg::BOX_W;

    logic signed [CW-1:0] prev_x_reg;
    logic signed [CW-1:0] prev_x_next;
    logic signed [CW-1:0] prev_y_reg;
    logic signed [CW-1:0] prev_y_next;
    vtdb_pkg::box_t       box_reg;
    vtdb_pkg::box_t       box_next;

    logic signed [CW:0]   limit;
    logic signed [CW:0]   neg_limit;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic                 short_step;
    logic signed [CW-1:0] min_x_w;
    logic signed [CW-1:0] max_x_w;
    logic signed [CW-1:0] min_y_w;
    logic signed [CW-1:0] max_y_w;

    always_comb begin
        limit     = (scale_level < vtdb_pkg::SCALE_COARSE) ? vtdb_pkg::LIMIT_FINE
                                                           : vtdb_pkg::LIMIT_COARSE;
        neg_limit = -limit;
        dx = $signed({point_x[CW-1], point_x}) - $signed({prev_x_reg[CW-1], prev_x_reg});
        dy = $signed({point_y[CW-1], point_y}) - $signed({prev_y_reg[CW-1], prev_y_reg});
        short_step = (dx < limit) && (dx > neg_limit) && (dy < limit) && (dy > neg_limit);
        kept = first_vertex || last_vertex || !short_step;

        min_x_w = $signed({{(CW - BW){box_reg.min_x[BW-1]}}, box_reg.min_x});
        max_x_w = $signed({{(CW - BW){box_reg.max_x[BW-1]}}, box_reg.max_x});
        min_y_w = $signed({{(CW - BW){box_reg.min_y[BW-1]}}, box_reg.min_y});
        max_y_w = $signed({{(CW - BW){box_reg.max_y[BW-1]}}, box_reg.max_y});

        box = box_reg;
        if (first_vertex) begin
            box.min_x = point_x[BW-1:0];
            box.max_x = point_x[BW-1:0];
            box.min_y = point_y[BW-1:0];
            box.max_y = point_y[BW-1:0];
        end else if (kept) begin
            if (min_x_w > point_x) box.min_x = point_x[BW-1:0];
            if (max_x_w < point_x) box.max_x = point_x[BW-1:0];
            if (min_y_w > point_y) box.min_y = point_y[BW-1:0];
            if (max_y_w < point_y) box.max_y = point_y[BW-1:0];
        end

        box_next    = box_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        if (update) begin
            box_next = box;
            if (kept) begin
                prev_x_next = point_x;
                prev_y_next = point_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_x_reg <= '0;
            prev_y_reg <= '0;
            box_reg    <= '0;
        end else begin
            prev_x_reg <= prev_x_next;
            prev_y_reg <= prev_y_next;
            box_reg    <= box_next;
        end
    end

endmodule

// ----- sv/vertex_transform_decimate_bbox.sv -----
// Top level: input register, transform and decimation logic, result register.
// Path: a vertex taken at the input passes the input register and then the result register
// before its result transaction is offered; a full result register can stall it in between.
// Throughput: one vertex per cycle unless m_ready stalls; the decimation state updates with each vertex.
// Ready stalls only when both the input and the result register are full and m_ready is low.
// Reset (aresetn low, synchronous) empties both registers, loads register defaults,
// and clears the last kept vertex and the bounding box to zero.
module vertex_transform_decimate_bbox (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic [vtdb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [vtdb_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [vtdb_pkg::RAW_W-1:0]              s_raw_x,
    input  logic [vtdb_pkg::RAW_W-1:0]              s_raw_y,
    input  logic signed [vtdb_pkg::BASE_W-1:0]      s_base_x,
    input  logic signed [vtdb_pkg::BASE_W-1:0]      s_base_y,
    input  logic                                    s_first_vertex,
    input  logic                                    s_last_vertex,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [vtdb_pkg::COORD_W-1:0]     m_screen_x,
    output logic signed [vtdb_pkg::COORD_W-1:0]     m_screen_y,
    output logic                                    m_kept,
    output logic signed [vtdb_pkg::BOX_W-1:0]       m_box_min_x,
    output logic signed [vtdb_pkg::BOX_W-1:0]       m_box_max_x,
    output logic signed [vtdb_pkg::BOX_W-1:0]       m_box_min_y,
    output logic signed [vtdb_pkg::BOX_W-1:0]       m_box_max_y,
    output logic                                    m_end_of_line
);

    vtdb_pkg::cfg_t cfg;

    logic                                 in_valid_reg;
    logic                                 in_valid_next;
    logic [vtdb_pkg::RAW_W-1:0]           raw_x_reg;
    logic [vtdb_pkg::RAW_W-1:0]           raw_y_reg;
    logic signed [vtdb_pkg::BASE_W-1:0]   base_x_reg;
    logic signed [vtdb_pkg::BASE_W-1:0]   base_y_reg;
    logic                                 first_reg;
    logic                                 last_reg;

    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [vtdb_pkg::COORD_W-1:0]  screen_x_reg;
    logic signed [vtdb_pkg::COORD_W-1:0]  screen_y_reg;
    logic                                 kept_reg;
    vtdb_pkg::box_t                       box_reg;
    logic                                 eol_reg;
    logic                                 first_out_reg;

    logic                                 out_free;
    logic                                 advance;
    logic                                 in_take;
    logic signed [vtdb_pkg::COORD_W-1:0]  point_x;
    logic signed [vtdb_pkg::COORD_W-1:0]  point_y;
    logic                                 kept;
    vtdb_pkg::box_t                       box;

    vtdb_config u_config (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vtdb_transform u_transform (
        .cfg     (cfg),
        .raw_x   (raw_x_reg),
        .raw_y   (raw_y_reg),
        .base_x  (base_x_reg),
        .base_y  (base_y_reg),
        .point_x (point_x),
        .point_y (point_y)
    );

    vtdb_decimate u_decimate (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .scale_level  (cfg.scale_level),
        .update       (advance),
        .point_x      (point_x),
        .point_y      (point_y),
        .first_vertex (first_reg),
        .last_vertex  (last_reg),
        .kept         (kept),
        .box          (box)
    );

    always_comb begin
        out_free       = !out_valid_reg || m_ready;
        advance        = in_valid_reg && out_free;
        s_ready        = !in_valid_reg || out_free;
        in_take        = s_valid && s_ready;
        in_valid_next  = in_take || (in_valid_reg && !out_free);
        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            raw_x_reg  <= s_raw_x;
            raw_y_reg  <= s_raw_y;
            base_x_reg <= s_base_x;
            base_y_reg <= s_base_y;
            first_reg  <= s_first_vertex;
            last_reg   <= s_last_vertex;
        end
        if (advance) begin
            screen_x_reg  <= point_x;
            screen_y_reg  <= point_y;
            kept_reg      <= kept;
            box_reg       <= box;
            eol_reg       <= last_reg;
            first_out_reg <= first_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_screen_x    = screen_x_reg;
    assign m_screen_y    = screen_y_reg;
    assign m_kept        = kept_reg;
    assign m_box_min_x   = box_reg.min_x;
    assign m_box_max_x   = box_reg.max_x;
    assign m_box_min_y   = box_reg.min_y;
    assign m_box_max_y   = box_reg.max_y;
    assign m_end_of_line = eol_reg;

`ifndef NO_ASSERTIONS
    // a first vertex restarts the box at its own truncated position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && first_out_reg) |-> (m_kept && m_box_min_x == m_screen_x[15:0]
            && m_box_max_y == m_screen_y[15:0]))
        else $error("first vertex did not restart the bounding box");

    // the last vertex of a polyline is never dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_end_of_line) |-> m_kept)
        else $error("last vertex dropped");

    // input stalls only while both stages hold a transaction and the result is not accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled with room in the pipeline");

    // a transaction moved to the result stage shows up as valid next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result lost after advancing");
`endif

endmodule
